>>> hw/rtl/spm_pkg.sv
// Shared types and constants for the square matrix power block.
// Used by the top level, its port checker and the testbench; depends on nothing else.
package spm_pkg;

    // Fixed widths of the payload and the configuration registers
    localparam int DATA_W     = 32;
    localparam int ORDER_W    = 4;
    localparam int EXP_W      = 8;
    localparam int POS_W      = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    // Load position saturates here
    localparam logic [POS_W-1:0] POS_MAX = 7'd127;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ORDER = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXP   = 1'b1;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DRAIN,
        ST_OUT,
        ST_ERR
    } t_state;

endpackage

>>> hw/rtl/spm_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// Stand-alone; depth is two to the power of the address width.
module spm_ram #(
    parameter int WIDTH  = 32,
    parameter int ADDR_W = 6
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [2**ADDR_W];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/square_matrix_power_top.sv
// Square matrix power: top level with load logic, multiply-accumulate sequencer and output.
// Depends on spm_pkg and spm_ram.
//
// Base matrix words load one per cycle while idle, in row-major order; the word
// with tlast starts the run, which uses the order in effect at that word. The
// block then multiplies a running product (the identity at first) by the base
// exponent times. One multiply-accumulate issues per cycle from the base memory
// and the product memory; after the last issue of a multiplication the read,
// multiply and accumulate stages drain before the product banks swap. The result
// then leaves with a registered read of the product memory ahead of each word, so
// reads and output loads alternate; with an exponent of zero the identity needs
// no read and leaves at one word a cycle while the output is not stalled. An
// error gives a single word. No new word is taken from the input between the
// final word and the last result word entering the output register.
module square_matrix_power_top #(
    parameter int MAX_ORDER = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Configuration write port
    input  logic                          i_cfg_we,
    input  logic [spm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [spm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // Input stream
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [spm_pkg::DATA_W-1:0]     i_s_tdata,   // [31:0] element
    input  logic                          i_s_tlast,   // final_element
    // Output stream
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [spm_pkg::DATA_W-1:0]     o_m_tdata,   // [31:0] value
    output logic                          o_m_tuser,   // [0] failed
    output logic                          o_m_tlast    // last_of_run
);

    localparam int CELLS = MAX_ORDER * MAX_ORDER;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int CW    = $clog2(MAX_ORDER + 1);
    localparam int DW    = spm_pkg::DATA_W;

    // Configuration registers
    logic [spm_pkg::ORDER_W-1:0] r_order;
    logic [spm_pkg::EXP_W-1:0]   r_exponent;

    // Control state
    spm_pkg::t_state r_state, n_state;
    logic [spm_pkg::POS_W-1:0] r_load_pos;
    logic [CW-1:0]             r_n;
    logic [spm_pkg::EXP_W-1:0] r_exp_left;
    logic                      r_ident;
    logic                      r_bank;
    logic [CW-1:0]             r_r, r_c, r_k;
    logic [AW-1:0]             r_rb, r_kb;

    // Pipeline stages: read, multiply, accumulate
    logic          r_p1_valid, r_p1_first, r_p1_last, r_p1_one;
    logic [AW-1:0] r_p1_waddr;
    logic          r_p2_valid, r_p2_first, r_p2_last;
    logic [AW-1:0] r_p2_waddr;
    logic [DW-1:0] r_p2_prod;
    logic [DW-1:0] r_acc;

    // Output register and read-ready flag
    logic          r_ov;
    logic [DW-1:0] r_odata;
    logic          r_ofail, r_olast;
    logic          r_rd_ok;

    logic [CW-1:0]  w_ncfg;
    logic [15:0]    w_cells;
    logic [15:0]    w_pos16;
    logic           w_in_acc, w_start;
    logic           w_base_we;
    logic [DW-1:0]  w_base_rdata, w_prod_rdata;
    logic [AW-1:0]  w_base_raddr;
    logic [AW:0]    w_prod_raddr, w_prod_waddr;
    logic [CW-1:0]  w_nm1;
    logic           w_k_end, w_c_end, w_r_end;
    logic           w_issue, w_issue_end;
    logic           w_drained, w_out_phase;
    logic [DW-1:0]  w_a, w_mul, w_sum;
    logic           w_prod_we, w_neg;
    logic           w_ov_free, w_out_load, w_out_end, w_mul_phase;

    // Order in use, clamped to 1..MAX_ORDER
    always_comb begin
        if (r_order == '0) begin
            w_ncfg = CW'(1);
        end else if (8'(r_order) > 8'(MAX_ORDER)) begin
            w_ncfg = CW'(MAX_ORDER);
        end else begin
            w_ncfg = CW'(r_order);
        end
    end

    assign w_cells   = 16'(w_ncfg) * 16'(w_ncfg);
    assign w_pos16   = 16'(r_load_pos);
    assign w_in_acc  = i_s_tvalid && o_s_tready;
    assign w_start   = w_in_acc && i_s_tlast;
    assign w_base_we = w_in_acc && (w_pos16 < w_cells);

    // Loop bounds of the multiply sequencer
    assign w_nm1       = r_n - CW'(1);
    assign w_k_end     = (r_k == w_nm1);
    assign w_c_end     = (r_c == w_nm1);
    assign w_r_end     = (r_r == w_nm1);
    assign w_issue_end = w_issue && w_k_end && w_c_end && w_r_end;
    assign w_drained   = !r_p1_valid && !r_p2_valid;

    // Memory addresses: previous product at r*n+k, base at k*n+c, output at r*n+c
    assign w_base_raddr = r_kb + AW'(r_c);
    assign w_prod_raddr = {r_bank, r_rb + AW'(w_out_phase ? r_c : r_k)};
    assign w_prod_waddr = {~r_bank, r_p2_waddr};

    spm_ram #(
        .WIDTH  (DW),
        .ADDR_W (AW)
    ) u_base_ram (
        .i_clk   (i_clk),
        .i_we    (w_base_we),
        .i_waddr (w_pos16[AW-1:0]),
        .i_wdata (i_s_tdata),
        .i_raddr (w_base_raddr),
        .o_rdata (w_base_rdata)
    );

    // Two product banks: one read as the previous product, the other written
    spm_ram #(
        .WIDTH  (DW),
        .ADDR_W (AW + 1)
    ) u_prod_ram (
        .i_clk   (i_clk),
        .i_we    (w_prod_we),
        .i_waddr (w_prod_waddr),
        .i_wdata (w_sum),
        .i_raddr (w_prod_raddr),
        .o_rdata (w_prod_rdata)
    );

    // Multiply and accumulate datapath; the first pass uses a virtual identity
    assign w_a       = r_ident ? DW'(r_p1_one) : w_prod_rdata;
    assign w_mul     = w_a * w_base_rdata;
    assign w_sum     = r_p2_first ? r_p2_prod : r_acc + r_p2_prod;
    assign w_prod_we = r_p2_valid && r_p2_last && w_mul_phase;
    assign w_neg     = w_prod_we && w_sum[DW-1];

    // Output register handshake
    assign w_ov_free  = !r_ov || i_m_tready;
    assign w_out_load = w_out_phase && w_ov_free && (r_ident || r_rd_ok);
    assign w_out_end  = w_c_end && w_r_end;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            spm_pkg::ST_IDLE: begin
                if (w_start) begin
                    n_state = (r_exponent == '0) ? spm_pkg::ST_OUT : spm_pkg::ST_MUL;
                end
            end
            spm_pkg::ST_MUL: begin
                if (w_neg) begin
                    n_state = spm_pkg::ST_ERR;
                end else if (w_issue_end) begin
                    n_state = spm_pkg::ST_DRAIN;
                end
            end
            spm_pkg::ST_DRAIN: begin
                if (w_neg) begin
                    n_state = spm_pkg::ST_ERR;
                end else if (w_drained) begin
                    n_state = (r_exp_left == spm_pkg::EXP_W'(1)) ? spm_pkg::ST_OUT
                                                                 : spm_pkg::ST_MUL;
                end
            end
            spm_pkg::ST_OUT: begin
                if (w_out_load && w_out_end) begin
                    n_state = spm_pkg::ST_IDLE;
                end
            end
            spm_pkg::ST_ERR: begin
                if (w_ov_free) begin
                    n_state = spm_pkg::ST_IDLE;
                end
            end
            default: n_state = spm_pkg::ST_IDLE;
        endcase
    end

    // State decoded controls
    always_comb begin
        o_s_tready  = 1'b0;
        w_issue     = 1'b0;
        w_out_phase = 1'b0;
        w_mul_phase = 1'b0;
        case (r_state)
            spm_pkg::ST_IDLE:  o_s_tready = 1'b1;
            spm_pkg::ST_MUL: begin
                w_issue     = 1'b1;
                w_mul_phase = 1'b1;
            end
            spm_pkg::ST_DRAIN: w_mul_phase = 1'b1;
            spm_pkg::ST_OUT:   w_out_phase = 1'b1;
            default: ;
        endcase
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order    <= spm_pkg::ORDER_W'(1);
            r_exponent <= spm_pkg::EXP_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                spm_pkg::CFG_ORDER: r_order    <= i_cfg_data[spm_pkg::ORDER_W-1:0];
                spm_pkg::CFG_EXP:   r_exponent <= i_cfg_data[spm_pkg::EXP_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer state, load position, run control and loop counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= spm_pkg::ST_IDLE;
            r_load_pos <= '0;
            r_n        <= CW'(1);
            r_exp_left <= '0;
            r_ident    <= 1'b1;
            r_bank     <= 1'b0;
            r_r        <= '0;
            r_c        <= '0;
            r_k        <= '0;
            r_rb       <= '0;
            r_kb       <= '0;
        end else begin
            r_state <= n_state;
            if (w_in_acc) begin
                if (i_s_tlast) begin
                    r_load_pos <= '0;
                end else if (r_load_pos < spm_pkg::POS_MAX) begin
                    r_load_pos <= r_load_pos + spm_pkg::POS_W'(1);
                end
            end
            if (w_start) begin
                r_n        <= w_ncfg;
                r_exp_left <= r_exponent;
                r_ident    <= 1'b1;
                r_r        <= '0;
                r_c        <= '0;
                r_k        <= '0;
                r_rb       <= '0;
                r_kb       <= '0;
            end else if (r_state == spm_pkg::ST_DRAIN && !w_neg && w_drained) begin
                // One multiplication done: swap banks and rewind the loops
                r_exp_left <= r_exp_left - spm_pkg::EXP_W'(1);
                r_ident    <= 1'b0;
                r_bank     <= ~r_bank;
                r_r        <= '0;
                r_c        <= '0;
                r_k        <= '0;
                r_rb       <= '0;
                r_kb       <= '0;
            end else if (w_issue || w_out_load) begin
                // Inner loop over k only while multiplying
                if (w_issue && !w_k_end) begin
                    r_k  <= r_k + CW'(1);
                    r_kb <= r_kb + AW'(r_n);
                end else begin
                    r_k  <= '0;
                    r_kb <= '0;
                    if (!w_c_end) begin
                        r_c <= r_c + CW'(1);
                    end else begin
                        r_c <= '0;
                        if (!w_r_end) begin
                            r_r  <= r_r + CW'(1);
                            r_rb <= r_rb + AW'(r_n);
                        end else begin
                            r_r  <= '0;
                            r_rb <= '0;
                        end
                    end
                end
            end
        end
    end

    // Pipeline valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
            r_p2_valid <= 1'b0;
        end else begin
            r_p1_valid <= w_issue && !w_neg;
            r_p2_valid <= r_p1_valid && !w_neg;
        end
    end

    // Pipeline payload: tags, product and accumulator
    always_ff @(posedge i_clk) begin
        r_p1_first <= (r_k == '0);
        r_p1_last  <= w_k_end;
        r_p1_one   <= (r_k == r_r);
        r_p1_waddr <= r_rb + AW'(r_c);
        r_p2_first <= r_p1_first;
        r_p2_last  <= r_p1_last;
        r_p2_waddr <= r_p1_waddr;
        r_p2_prod  <= w_mul;
        if (r_p2_valid) begin
            r_acc <= w_sum;
        end
    end

    // Output register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov    <= 1'b0;
            r_rd_ok <= 1'b0;
        end else begin
            r_rd_ok <= w_out_phase && !w_out_load;
            if (w_out_load || (r_state == spm_pkg::ST_ERR && w_ov_free)) begin
                r_ov <= 1'b1;
            end else if (i_m_tready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Output word payload: result element or the error word
    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_odata <= r_ident ? DW'(r_r == r_c) : w_prod_rdata;
            r_ofail <= 1'b0;
            r_olast <= w_out_end;
        end else if (r_state == spm_pkg::ST_ERR && w_ov_free) begin
            r_odata <= '0;
            r_ofail <= 1'b1;
            r_olast <= 1'b1;
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = r_odata;
    assign o_m_tuser  = r_ofail;
    assign o_m_tlast  = r_olast;

endmodule

>>> hw/rtl/spm_checker.sv
// Port-level checker for the square matrix power top level, with its bind.
// Depends on spm_pkg; attaches to square_matrix_power_top.
module spm_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_s_tvalid,
    input logic                          o_s_tready,
    input logic                          i_s_tlast,
    input logic                          o_m_tvalid,
    input logic                          i_m_tready,
    input logic [spm_pkg::DATA_W-1:0]     o_m_tdata,
    input logic                          o_m_tuser,
    input logic                          o_m_tlast
);

    // A stalled output word holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("output word changed while stalled");

    // The error word carries zero data and closes the run
    a_err_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tdata == '0 && o_m_tlast)
        else $error("malformed error word");

    // The final input word starts a run, so input stops at once
    a_run_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && i_s_tlast |=> !o_s_tready)
        else $error("input still ready after the final word");

    // Reset empties the output register
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

endmodule

bind square_matrix_power_top spm_checker u_spm_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tlast  (i_s_tlast),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);

>>> sim/tb.sv
// Self-checking testbench for square_matrix_power_top: loads base matrices over the
// input stream, predicts each power or error word with a scoreboard class, and checks
// every output word. Depends on spm_pkg and the block's RTL only.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_ORDER = 8;
    localparam int CELLS     = MAX_ORDER * MAX_ORDER;
    localparam int SETTLE    = 16;
    localparam int LONG_HOLD = 300;
    localparam int ITEM_GOAL = 160;
    localparam int LIMIT     = 2_000_000;

    // One output word as the block presents it
    typedef struct packed {
        logic [31:0] value;
        logic        failed;
        logic        last;
    } t_result_word;

    // Ways of filling a base matrix
    typedef enum int {
        FILL_FULL,
        FILL_SMALL,
        FILL_PERM,
        FILL_DIAG,
        FILL_SIGNED
    } t_fill;

    // Scoreboard: mirrors the base store and registers, predicts each run
    class t_power_scoreboard;
        logic [31:0]  base_words [CELLS];
        bit           loaded [CELLS];
        logic [3:0]   order_reg;
        logic [7:0]   exp_reg;
        int           load_pos;
        t_result_word pending_words [$];
        int           errors;

        function new();
            order_reg = 4'd1;
            exp_reg   = 8'd1;
            load_pos  = 0;
            errors    = 0;
            foreach (loaded[i]) loaded[i] = 1'b0;
        endfunction

        function void write_register(logic [spm_pkg::CFG_IDX_W-1:0] idx, logic [7:0] data);
            case (idx)
                spm_pkg::CFG_ORDER: order_reg = data[3:0];
                spm_pkg::CFG_EXP:   exp_reg   = data;
                default: ;
            endcase
        endfunction

        // Out-of-range orders are clamped into 1..MAX_ORDER
        function int order_in_effect();
            if (order_reg == 0) return 1;
            if (order_reg > MAX_ORDER) return MAX_ORDER;
            return int'(order_reg);
        endfunction

        function int pending();
            return pending_words.size();
        endfunction

        function void flag_mismatch(string msg);
            errors++;
            if (errors <= 10) $display("[%0t] MISMATCH: %s", $realtime, msg);
        endfunction

        // Repeated multiplication from the identity; stops at the first negative element
        function void raise_to_power(int n);
            logic [31:0]  prod [CELLS];
            logic [31:0]  prev [CELLS];
            logic [31:0]  acc;
            bit           negative;
            t_result_word word;
            negative = 1'b0;
            for (int i = 0; i < n * n; i++) prod[i] = (i / n == i % n) ? 32'd1 : 32'd0;
            for (int e = 0; e < int'(exp_reg) && !negative; e++) begin
                prev = prod;
                for (int r = 0; r < n && !negative; r++) begin
                    for (int c = 0; c < n && !negative; c++) begin
                        acc = 32'd0;
                        for (int k = 0; k < n; k++)
                            acc = acc + prev[r * n + k] * base_words[k * n + c];
                        prod[r * n + c] = acc;
                        negative = acc[31];
                    end
                end
            end
            if (negative) begin
                word = '{value: 32'd0, failed: 1'b1, last: 1'b1};
                pending_words.push_back(word);
            end else begin
                for (int i = 0; i < n * n; i++) begin
                    word = '{value: prod[i], failed: 1'b0, last: (i == n * n - 1)};
                    pending_words.push_back(word);
                end
            end
        endfunction

        function void note_input(logic [31:0] element, logic final_element);
            int n;
            n = order_in_effect();
            if (load_pos < n * n) begin
                base_words[load_pos] = element;
                loaded[load_pos]     = 1'b1;
            end
            if (!final_element) begin
                if (load_pos < int'(spm_pkg::POS_MAX)) load_pos++;
            end else begin
                load_pos = 0;
                raise_to_power(n);
            end
        endfunction

        function void check_result(t_result_word got);
            t_result_word want;
            if (pending_words.size() == 0) begin
                flag_mismatch($sformatf("unexpected word value=%0d failed=%0b last=%0b",
                              $signed(got.value), got.failed, got.last));
            end else begin
                want = pending_words.pop_front();
                if (got.value !== want.value || got.failed !== want.failed ||
                    got.last !== want.last)
                    flag_mismatch($sformatf(
                        "expected value=%0d failed=%0b last=%0b, got value=%0d failed=%0b last=%0b",
                        $signed(want.value), want.failed, want.last,
                        $signed(got.value), got.failed, got.last));
            end
        endfunction
    endclass

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_cfg_we = 1'b0;
    logic [spm_pkg::CFG_IDX_W-1:0]   i_cfg_idx = spm_pkg::CFG_ORDER;
    logic [spm_pkg::CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                            i_s_tvalid = 1'b0;
    logic                            o_s_tready;
    logic [spm_pkg::DATA_W-1:0]      i_s_tdata = '0;   // [31:0] element
    logic                            i_s_tlast = 1'b0; // final_element
    logic                            o_m_tvalid;
    logic                            i_m_tready = 1'b0;
    logic [spm_pkg::DATA_W-1:0]      o_m_tdata;        // [31:0] value
    logic                            o_m_tuser;        // [0] failed
    logic                            o_m_tlast;        // last_of_run

    t_power_scoreboard sb;
    int  burst_left = 0;
    bit  gaps_on = 1'b1;
    int  hold_requests = 0;
    int  holds_served = 0;
    int  cycle_count = 0;
    int  words_sent = 0;
    int  perm [MAX_ORDER];

    square_matrix_power_top #(.MAX_ORDER(MAX_ORDER)) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    always #5 i_clk = ~i_clk;

    // Run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Monitor: check output words first, then record accepted input words
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready)
                sb.check_result('{value: o_m_tdata, failed: o_m_tuser, last: o_m_tlast});
            if (i_s_tvalid && o_s_tready)
                sb.note_input(i_s_tdata, i_s_tlast);
        end
    end

    // Receiver: stall patterns in segments, plus long holds on request
    initial begin
        int mode;
        int seg;
        int tick;
        tick = 0;
        forever begin
            mode = $urandom_range(0, 3);
            seg  = $urandom_range(10, 150);
            repeat (seg) begin
                @(posedge i_clk);
                tick++;
                if (hold_requests != holds_served) begin
                    holds_served++;
                    i_m_tready <= 1'b0;
                    repeat (LONG_HOLD) @(posedge i_clk);
                end else begin
                    case (mode)
                        0: i_m_tready <= 1'b1;
                        1: i_m_tready <= 1'($urandom_range(0, 1));
                        2: i_m_tready <= (tick % 3 == 0);
                        default: i_m_tready <= ($urandom_range(0, 3) == 0);
                    endcase
                end
            end
        end
    end

    // Offer one word; opens a new burst after a random gap when the last one ran out
    task automatic drive_word(input logic [31:0] element, input logic final_element);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if (gaps_on) begin
                gap = $urandom_range(1, 6);
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= element;
        i_s_tlast  <= final_element;
        @(posedge i_clk);
        while (o_s_tready !== 1'b1) @(posedge i_clk);
        words_sent++;
    endtask

    // Stop offering and wait until every predicted word has come out
    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [spm_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        sb.write_register(idx, data);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Send one load of count words, the last one marked final
    task automatic send_run(input t_fill fill, input int count);
        int n;
        int j;
        int tmp;
        int r;
        int c;
        logic [31:0] w;
        n = sb.order_in_effect();
        for (int i = 0; i < n; i++) perm[i] = i;
        for (int i = n - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = perm[i];
            perm[i] = perm[j];
            perm[j] = tmp;
        end
        for (int p = 0; p < count; p++) begin
            r = p / n;
            c = p % n;
            if (p >= n * n) w = $urandom();
            else begin
                case (fill)
                    FILL_SMALL:  w = $urandom_range(0, 2);
                    FILL_PERM:   w = (perm[r] == c) ? 32'd1 : 32'd0;
                    FILL_DIAG:   w = (r == c) ? 32'($urandom_range(0, 3)) : 32'd0;
                    FILL_SIGNED: w = ($urandom_range(0, 4) == 0) ?
                                     32'(0 - $urandom_range(1, 3)) : 32'($urandom_range(0, 3));
                    default:     w = $urandom();
                endcase
            end
            drive_word(w, p == count - 1);
        end
    endtask

    // Main sequence: directed cases, load-position saturation, then random phases
    initial begin
        int phase;
        int pick;
        int order_raw;
        int n;
        int cells;
        int exp_val;
        int runs;
        int count;
        int k;
        t_fill fill;

        sb = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset configuration (order 1, exponent 1) with extreme elements
        drive_word(32'd5, 1'b1);
        drive_word(32'h7FFF_FFFF, 1'b1);
        drive_word(32'h8000_0000, 1'b1);
        drive_word(32'd0, 1'b1);
        drive_word(32'hFFFF_FFFF, 1'b1);
        drain_results();

        // Exponent zero gives the identity even for a negative base
        write_reg(spm_pkg::CFG_ORDER, 8'd2);
        write_reg(spm_pkg::CFG_EXP, 8'd0);
        drive_word(32'h8000_0000, 1'b0);
        drive_word(32'hFFFF_FFFF, 1'b0);
        drive_word(32'h7FFF_FFFF, 1'b0);
        drive_word(32'd3, 1'b1);
        drain_results();

        // Too few words: the bottom row stays from the previous load
        write_reg(spm_pkg::CFG_EXP, 8'd1);
        drive_word(32'd1, 1'b0);
        drive_word(32'd0, 1'b1);
        drain_results();

        // Order zero acts as one; largest exponent
        write_reg(spm_pkg::CFG_ORDER, 8'd0);
        write_reg(spm_pkg::CFG_EXP, 8'd255);
        drive_word(32'd1, 1'b1);
        drive_word(32'd3, 1'b1);
        drain_results();

        // Too many words: everything past the first is ignored
        write_reg(spm_pkg::CFG_EXP, 8'd2);
        drive_word(32'd7, 1'b0);
        drive_word(32'd9, 1'b0);
        drive_word(32'd11, 1'b0);
        drive_word(32'd13, 1'b1);
        drain_results();

        write_reg(spm_pkg::CFG_ORDER, 8'd3);
        write_reg(spm_pkg::CFG_EXP, 8'd3);
        send_run(FILL_SMALL, 9);
        drain_results();

        // Largest order, clamped from 15, with the largest exponent. The load runs
        // past the saturation point of the load position, so a wrap would put the
        // final random word onto the first cell.
        write_reg(spm_pkg::CFG_ORDER, 8'd15);
        write_reg(spm_pkg::CFG_EXP, 8'd255);
        send_run(FILL_PERM, int'(spm_pkg::POS_MAX) + 2);
        drain_results();

        phase = 0;
        do begin
            phase++;
            pick = $urandom_range(0, 99);
            if (pick < 5) order_raw = 0;
            else if (pick < 75) order_raw = $urandom_range(1, 3);
            else if (pick < 90) order_raw = $urandom_range(4, 5);
            else if (pick < 96) order_raw = $urandom_range(6, 8);
            else order_raw = $urandom_range(9, 15);
            write_reg(spm_pkg::CFG_ORDER, 8'(order_raw));
            n = sb.order_in_effect();
            cells = n * n;

            // Long exponents only where the matrix is small
            pick = $urandom_range(0, 99);
            if (n <= 2 && pick < 10)
                exp_val = $urandom_range(0, 1) ? 255 : $urandom_range(100, 254);
            else if (n <= 3 && pick < 35) exp_val = $urandom_range(5, 16);
            else exp_val = $urandom_range(0, (n > 4) ? 2 : 4);
            write_reg(spm_pkg::CFG_EXP, 8'(exp_val));

            gaps_on = ($urandom_range(0, 3) != 0);
            runs = $urandom_range(1, 4);
            if (phase == 1 || $urandom_range(0, 9) == 0) begin
                hold_requests++;
                if (runs < 3) runs = 3;
            end

            repeat (runs) begin
                pick = $urandom_range(0, 99);
                if (pick < 12) fill = FILL_FULL;
                else if (pick < 35) fill = FILL_SMALL;
                else if (pick < 60) fill = FILL_PERM;
                else if (pick < 80) fill = FILL_DIAG;
                else fill = FILL_SIGNED;

                // Mostly exact loads; some long, some short over already written cells
                count = cells;
                pick = $urandom_range(0, 9);
                if (pick == 0) begin
                    count = cells + $urandom_range(1, 3);
                end else if (pick == 1) begin
                    k = cells;
                    while (k > 0 && sb.loaded[k - 1]) k--;
                    if (k < 1) k = 1;
                    if (k <= cells - 1) count = $urandom_range(k, cells - 1);
                end
                send_run(fill, count);
            end
            drain_results();
        end while (words_sent < ITEM_GOAL);

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
